>>> hdl/clock_discipline_loop_assert.svh
// assertion macros for the clock discipline loop checker
`ifndef CLOCK_DISCIPLINE_LOOP_ASSERT_SVH
`define CLOCK_DISCIPLINE_LOOP_ASSERT_SVH

// same-cycle implication
`define CDL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clock discipline loop check failed");

// next-cycle implication
`define CDL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clock discipline loop check failed");

`endif

>>> hdl/cdl_pkg.sv
// shared constants, types and helpers for the clock discipline loop
package cdl_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;
  localparam int ACC_W      = 30;
  localparam int HZ_CFG_W   = 40;
  localparam int HZ_W       = 41;
  localparam int AVG_W      = 34;

  localparam logic [CFG_IDX_W-1:0] REG_ACCURACY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_ACC = 2'd3;

  localparam logic [ACC_W-1:0]    RST_ACCURACY = 30'd1000000;
  localparam logic [HZ_CFG_W-1:0] RST_NOMINAL  = 40'd100000000;
  localparam logic [HZ_CFG_W-1:0] RST_START    = 40'd100000000;
  localparam logic [HZ_CFG_W-1:0] RST_TICK_ACC = 40'd100000;

  localparam logic [15:0] MIN_SAMPLE_SECS = 16'd60;
  localparam logic [15:0] SECS_STEP       = 16'd60;
  localparam logic [15:0] NOSAMPLE_CAP    = 16'd900;
  localparam logic [16:0] MAX_SECS        = 17'd65535;

  localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
  localparam logic signed [64:0] STEP_LIMIT = 65'sd10000000000;
  localparam logic signed [63:0] DAY_NS     = 64'sd86400000000000;

  typedef enum logic [1:0] {
    ACT_IGNORE = 2'd0,
    ACT_STEP   = 2'd1,
    ACT_SLEW   = 2'd2
  } action_t;

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_OFFS     = 15'b000000000000010,
    ST_PRUNE_RD = 15'b000000000000100,
    ST_PRUNE_CK = 15'b000000000001000,
    ST_SRCH_RD  = 15'b000000000010000,
    ST_SRCH_CK  = 15'b000000000100000,
    ST_DT       = 15'b000000001000000,
    ST_MUL      = 15'b000000010000000,
    ST_DIVCHK   = 15'b000000100000000,
    ST_DIV      = 15'b000001000000000,
    ST_EST      = 15'b000010000000000,
    ST_DHZ      = 15'b000100000000000,
    ST_CAPCHK   = 15'b001000000000000,
    ST_WRITE    = 15'b010000000000000,
    ST_OUT      = 15'b100000000000000
  } state_t;

  typedef enum logic {
    OP_EST = 1'b0,
    OP_CAP = 1'b1
  } op_t;

  // ring slot of entry idx counted from head
  function automatic logic [HIST_AW-1:0] slot_of(input logic [HIST_AW-1:0] head,
                                                 input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
    if (sum >= (CNT_W+1)'(HIST_DEPTH)) begin
      sum = sum - (CNT_W+1)'(HIST_DEPTH);
    end
    return sum[HIST_AW-1:0];
  endfunction

endpackage

>>> hdl/cdl_if.sv
// valid/ready channels for the sample and result words
interface cdl_in_if;
  logic               valid;
  logic               ready;
  logic               sample_present;
  logic signed [63:0] server_time;
  logic signed [63:0] local_time;
  logic        [63:0] tick_count;

  modport source(output valid, sample_present, server_time, local_time, tick_count,
                 input ready);
  modport sink(input valid, sample_present, server_time, local_time, tick_count,
               output ready);
endinterface

interface cdl_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [63:0] step_value;
  logic signed [34:0] slew_offset;
  logic        [17:0] slew_span;
  logic               hz_update;
  logic        [63:0] new_hz;
  logic        [15:0] sleep_secs;

  modport source(output valid, action, step_value, slew_offset, slew_span, hz_update,
                 new_hz, sleep_secs, input ready);
  modport sink(input valid, action, step_value, slew_offset, slew_span, hz_update,
               new_hz, sleep_secs, output ready);
endinterface

>>> hdl/cdl_ram.sv
// generic single-write, single-read RAM with registered read data
module cdl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/clock_discipline_loop.sv
// clock discipline loop: per-sample step/slew decision and tick frequency tracking
//
// One sample word is taken at a time; in_chan.ready is high only while the
// sequencer is idle. A missing, first or bad sample goes straight to the
// output state. A good sample walks the history ring, each pruned or walked
// entry read in a read state and checked in a check state on the single read
// port, then goes, where needed, through the tick-rate estimate (two 32x32
// partial products and a 64-step restoring divide) and the wait cap, which
// reuses the same multiplier and divider. Pruned plus walked entries never
// exceed the ring depth. The result waits in an output register, so the next
// sample is taken while the previous word is still pending; a finished sample
// holds in the last state until that word is taken. The history ring needs no
// clearing after reset; entries are read only once written.
module clock_discipline_loop (
  input  logic                          clk,
  input  logic                          rst_n,
  cdl_in_if.sink                        in_chan,
  cdl_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [cdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cdl_pkg::*;

  state_t state_r;
  op_t    op_r;

  logic [ACC_W-1:0]    accuracy_r;
  logic [HZ_CFG_W-1:0] nominal_r;
  logic [HZ_CFG_W-1:0] tick_acc_r;

  logic                seen_first_r;
  logic [15:0]         sample_r;
  logic [31:0]         wait_r;
  logic [AVG_W-1:0]    avg_r;
  logic [HZ_W-1:0]     cur_hz_r;
  logic [HZ_W-1:0]     nhz_r;
  logic [HIST_AW-1:0]  head_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    j_r;

  logic [63:0]         sraw_r, ltime_r, tick_r;
  logic [63:0]         sel_time_r, sel_ticks_r;
  logic [63:0]         dt_r, dhz_r;

  logic [63:0]         mul_x_r;
  logic [31:0]         mul_y_r;
  logic [63:0]         prod_r;
  logic [95:0]         acc_r;
  logic [1:0]          ph_r;

  logic [63:0]         div_rem_r, div_num_r, div_d_r;
  logic [5:0]          div_cnt_r;

  action_t             act_r;
  logic [63:0]         step_r;
  logic [34:0]         slew_r;
  logic [17:0]         span_r;
  logic                hz_upd_r;
  logic                out_valid_r;

  logic [1:0]      out_act_r;
  logic [63:0]     out_step_r;
  logic [34:0]     out_slew_r;
  logic [17:0]     out_span_r;
  logic            out_hz_upd_r;
  logic [HZ_W-1:0] out_hz_r;
  logic [15:0]     out_sleep_r;
  logic            out_load;

  logic [HIST_AW-1:0]  rd_addr, wr_addr;
  logic                wr_en;
  logic [63:0]         rd_time, rd_ticks;

  logic [63:0]         period;
  logic [31:0]         mul_a;
  logic [64:0]         div_r2;
  logic                div_ge;
  logic signed [64:0]  diff;
  logic                far;
  logic [34:0]         ad;
  logic [16:0]         s_up;
  logic [15:0]         s_new;
  logic signed [63:0]  dt_s;
  logic [63:0]         dticks;
  logic [HZ_W:0]       minhz, maxhz;
  logic [43:0]         damp;
  logic [63:0]         age;

  assign period  = {{(64-AVG_W-24){1'b0}}, avg_r, 24'd0};
  assign mul_a   = (ph_r == 2'd0) ? mul_x_r[31:0] : mul_x_r[63:32];
  assign div_r2  = {div_rem_r, div_num_r[63]};
  assign div_ge  = div_r2 >= {1'b0, div_d_r};
  assign diff    = $signed({1'b0, sraw_r}) - $signed({ltime_r[63], ltime_r});
  assign far     = (diff > STEP_LIMIT) || (diff < -STEP_LIMIT);
  assign ad      = diff[64] ? 35'(-diff) : diff[34:0];
  assign dt_s    = $signed(sraw_r) - $signed(sel_time_r);
  assign dticks  = tick_r - sel_ticks_r;
  assign minhz   = {1'b0, HZ_W'(nominal_r)} - {1'b0, HZ_W'(nominal_r >> 2)};
  assign maxhz   = {1'b0, HZ_W'(nominal_r)} + {1'b0, HZ_W'(nominal_r >> 2)};
  assign damp    = 44'(cur_hz_r) + 44'({cur_hz_r, 1'b0}) + 44'(div_num_r[HZ_W-1:0]);
  assign age     = sraw_r - rd_time;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_chan.ready);

  always_comb begin
    s_up = 17'(sample_r) + 17'(SECS_STEP);
    if (ad < 35'(accuracy_r >> 1)) begin
      s_new = (s_up > MAX_SECS) ? MAX_SECS[15:0] : s_up[15:0];
    end else if (ad > 35'(accuracy_r)) begin
      s_new = sample_r >> 1;
    end else begin
      s_new = (sample_r > SECS_STEP) ? sample_r - SECS_STEP : 16'd0;
    end
    if (s_new < MIN_SAMPLE_SECS) begin
      s_new = MIN_SAMPLE_SECS;
    end
  end

  assign rd_addr = (state_r == ST_PRUNE_RD) ? slot_of(head_r, CNT_W'(1))
                                            : slot_of(head_r, j_r);
  assign wr_en   = (state_r == ST_WRITE);
  assign wr_addr = (count_r >= CNT_W'(HIST_DEPTH)) ? head_r : slot_of(head_r, count_r);

  cdl_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_time_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(sraw_r), .raddr(rd_addr),
    .rdata(rd_time)
  );

  cdl_ram #(.WIDTH(64), .DEPTH(HIST_DEPTH)) u_ticks_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(tick_r), .raddr(rd_addr),
    .rdata(rd_ticks)
  );

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.action     = out_act_r;
  assign out_chan.step_value = $signed(out_step_r);
  assign out_chan.slew_offset = $signed(out_slew_r);
  assign out_chan.slew_span  = out_span_r;
  assign out_chan.hz_update  = out_hz_upd_r;
  assign out_chan.new_hz     = 64'(out_hz_r);
  assign out_chan.sleep_secs = out_sleep_r;

  // shared 32x32 multiplier
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_EST;
      accuracy_r   <= RST_ACCURACY;
      nominal_r    <= RST_NOMINAL;
      tick_acc_r   <= RST_TICK_ACC;
      seen_first_r <= 1'b0;
      sample_r     <= MIN_SAMPLE_SECS;
      wait_r       <= 32'(MIN_SAMPLE_SECS);
      avg_r        <= AVG_W'(RST_ACCURACY >> 1);
      cur_hz_r     <= HZ_W'(RST_START);
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_ACCURACY: begin
            accuracy_r <= cfg_data[ACC_W-1:0];
            if (!seen_first_r) begin
              avg_r <= AVG_W'(cfg_data[ACC_W-1:1]);
            end
          end
          REG_NOMINAL: nominal_r <= cfg_data[HZ_CFG_W-1:0];
          REG_START: begin
            if (!seen_first_r) begin
              cur_hz_r <= HZ_W'(cfg_data[HZ_CFG_W-1:0]);
            end
          end
          REG_TICK_ACC: tick_acc_r <= cfg_data[HZ_CFG_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            sraw_r   <= in_chan.server_time;
            ltime_r  <= in_chan.local_time;
            tick_r   <= in_chan.tick_count;
            act_r    <= ACT_IGNORE;
            step_r   <= '0;
            slew_r   <= '0;
            span_r   <= '0;
            hz_upd_r <= 1'b0;
            if (!in_chan.sample_present) begin
              if (sample_r > NOSAMPLE_CAP) begin
                wait_r <= 32'(NOSAMPLE_CAP);
              end
              state_r <= ST_OUT;
            end else if (in_chan.server_time[63] || !seen_first_r) begin
              seen_first_r <= 1'b1;
              state_r      <= ST_OUT;
            end else begin
              state_r <= ST_OFFS;
            end
          end
        end

        ST_OFFS: begin
          nhz_r <= cur_hz_r;
          j_r   <= '0;
          if (far) begin
            sample_r <= MIN_SAMPLE_SECS;
            act_r    <= ACT_STEP;
            step_r   <= sraw_r;
          end else begin
            avg_r    <= (avg_r >> 1) + AVG_W'(ad >> 1);
            sample_r <= s_new;
            wait_r   <= 32'(s_new);
            act_r    <= ACT_SLEW;
            slew_r   <= diff[34:0];
            span_r   <= {s_new, 2'b00};
          end
          state_r <= ST_PRUNE_RD;
        end

        ST_PRUNE_RD: begin
          if (count_r >= CNT_W'(2)) begin
            state_r <= ST_PRUNE_CK;
          end else begin
            state_r <= (count_r != '0) ? ST_SRCH_RD : ST_WRITE;
          end
        end

        ST_PRUNE_CK: begin
          if (($signed(sraw_r) - $signed(rd_time)) >= DAY_NS) begin
            head_r  <= slot_of(head_r, CNT_W'(1));
            count_r <= count_r - CNT_W'(1);
            state_r <= ST_PRUNE_RD;
          end else begin
            state_r <= ST_SRCH_RD;
          end
        end

        ST_SRCH_RD: state_r <= ST_SRCH_CK;

        ST_SRCH_CK: begin
          if (j_r == '0 || age >= period) begin
            sel_time_r  <= rd_time;
            sel_ticks_r <= rd_ticks;
          end
          if (age >= period && (j_r + CNT_W'(1)) < count_r) begin
            j_r     <= j_r + CNT_W'(1);
            state_r <= ST_SRCH_RD;
          end else begin
            state_r <= ST_DT;
          end
        end

        ST_DT: begin
          dt_r <= dt_s;
          if (dt_s > 64'sd0 && dticks != '0 && !dticks[63]) begin
            mul_x_r <= dticks;
            mul_y_r <= NS_PER_SEC;
            op_r    <= OP_EST;
            ph_r    <= 2'd0;
            state_r <= ST_MUL;
          end else begin
            state_r <= ST_WRITE;
          end
        end

        ST_MUL: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            acc_r <= 96'(prod_r);
          end else if (ph_r == 2'd2) begin
            acc_r   <= acc_r + {prod_r, 32'd0};
            state_r <= (op_r == OP_EST) ? ST_DIVCHK : ST_CAPCHK;
          end
        end

        ST_DIVCHK: begin
          if (64'(acc_r[95:64]) >= dt_r) begin
            div_num_r <= '1;
            state_r   <= ST_EST;
          end else begin
            div_rem_r <= 64'(acc_r[95:64]);
            div_num_r <= acc_r[63:0];
            div_d_r   <= dt_r;
            div_cnt_r <= '1;
            state_r   <= ST_DIV;
          end
        end

        ST_DIV: begin
          div_rem_r <= div_ge ? 64'(div_r2 - {1'b0, div_d_r}) : div_r2[63:0];
          div_num_r <= {div_num_r[62:0], div_ge};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == '0) begin
            state_r <= (op_r == OP_EST) ? ST_EST : ST_WRITE;
            if (op_r == OP_CAP) begin
              wait_r <= ({div_num_r[62:0], div_ge} < 64'(MIN_SAMPLE_SECS))
                        ? 32'(MIN_SAMPLE_SECS) : {div_num_r[30:0], div_ge};
            end
          end
        end

        ST_EST: begin
          if (div_num_r >= 64'(minhz) && div_num_r <= 64'(maxhz)) begin
            hz_upd_r <= 1'b1;
            nhz_r    <= (period > dt_r) ? damp[HZ_W+1:2] : div_num_r[HZ_W-1:0];
          end
          state_r <= ST_DHZ;
        end

        ST_DHZ: begin
          dhz_r   <= (nhz_r >= cur_hz_r) ? 64'(nhz_r - cur_hz_r) : 64'(cur_hz_r - nhz_r);
          mul_x_r <= (nhz_r >= cur_hz_r) ? 64'(nhz_r - cur_hz_r) : 64'(cur_hz_r - nhz_r);
          mul_y_r <= wait_r;
          op_r    <= OP_CAP;
          ph_r    <= 2'd0;
          state_r <= (nhz_r != cur_hz_r) ? ST_MUL : ST_WRITE;
        end

        ST_CAPCHK: begin
          if (acc_r[63:0] >= 64'(tick_acc_r)) begin
            div_rem_r <= '0;
            div_num_r <= 64'(tick_acc_r);
            div_d_r   <= dhz_r;
            div_cnt_r <= '1;
            state_r   <= ST_DIV;
          end else begin
            state_r <= ST_WRITE;
          end
        end

        ST_WRITE: begin
          cur_hz_r <= nhz_r;
          if (count_r >= CNT_W'(HIST_DEPTH)) begin
            head_r <= slot_of(head_r, CNT_W'(1));
          end else begin
            count_r <= count_r + CNT_W'(1);
          end
          state_r <= ST_OUT;
        end

        ST_OUT: begin
          if (out_load) begin
            out_act_r    <= act_r;
            out_step_r   <= step_r;
            out_slew_r   <= slew_r;
            out_span_r   <= span_r;
            out_hz_upd_r <= hz_upd_r;
            out_hz_r     <= cur_hz_r;
            out_sleep_r  <= wait_r[15:0];
            state_r      <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/cdl_checker.sv
// port-level checks for the clock discipline loop, bound to the top level
`include "clock_discipline_loop_assert.svh"

module cdl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  action,
  input logic [63:0] step_value,
  input logic [34:0] slew_offset,
  input logic [17:0] slew_span,
  input logic        hz_update
);
  import cdl_pkg::*;

  // a pending word stays until taken
  `CDL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // busy right after taking a sample
  `CDL_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a result only appears out of a busy sequencer
  `CDL_ASSERT_IMP(a_result_from_busy, $rose(out_valid), !$past(in_ready))
  // an ignored sample carries no correction
  `CDL_ASSERT_IMP(a_ignore_clean, out_valid && action == ACT_IGNORE,
                  step_value == '0 && slew_offset == '0 && slew_span == '0 && !hz_update)
  // a slew spans at least four minimum periods, others none
  `CDL_ASSERT_IMP(a_span_range, out_valid,
                  (action == ACT_SLEW) ? (slew_span >= 18'd240) : (slew_span == '0))

endmodule

bind clock_discipline_loop cdl_checker u_cdl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .action     (out_chan.action),
  .step_value (out_chan.step_value),
  .slew_offset(out_chan.slew_offset),
  .slew_span  (out_chan.slew_span),
  .hz_update  (out_chan.hz_update)
);

>>> tb/sv/testbench.sv
// self-checking testbench for the clock discipline loop with a built-in predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdl_pkg::*;

  localparam int DEPTH = 2048;
  localparam logic [63:0] LIMIT_NS = 64'd10000000000;
  localparam logic [63:0] ONE_DAY  = 64'd86400000000000;
  localparam logic [63:0] BILLION  = 64'd1000000000;

  typedef struct {
    action_t     action;
    logic [63:0] step_value;
    logic [34:0] slew_offset;
    logic [17:0] slew_span;
    logic        hz_update;
    logic [63:0] new_hz;
    logic [15:0] sleep_secs;
  } loop_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACCURACY;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cdl_in_if in_bus();
  cdl_out_if out_bus();

  clock_discipline_loop uut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_bus), .out_chan(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and loop state
  logic [63:0] acc_reg, nom_reg, start_reg, tacc_reg;
  logic        have_first;
  logic [31:0] period_secs, next_wait;
  logic [63:0] err_avg, freq_hz;
  logic [63:0] ring_time [DEPTH];
  logic [63:0] ring_ticks [DEPTH];
  logic [10:0] ring_head;
  int          ring_fill;

  loop_word_t pending_words[$];
  int mismatches = 0;
  int words_checked = 0, steps_seen = 0, slews_seen = 0, hz_seen = 0;
  int next_gap = 0;
  bit quiet = 0;
  int stall_left = 0;

  // stream generator state
  logic [63:0] gen_server, gen_ticks;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("timeout with %0d words outstanding", pending_words.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [10:0] ring_slot(int i);
    return ring_head + 11'(i);
  endfunction

  task automatic loop_reset_state();
    acc_reg = 64'd1000000; nom_reg = 64'd100000000;
    start_reg = 64'd100000000; tacc_reg = 64'd100000;
    have_first = 0; period_secs = 60; next_wait = 60;
    err_avg = acc_reg >> 1; freq_hz = start_reg;
    ring_head = '0; ring_fill = 0;
  endtask

  task automatic predict_loop(input logic p, input logic [63:0] srv, input logic [63:0] loc,
                              input logic [63:0] tck, output loop_word_t w);
    logic [63:0] mag, ad, per, ohz, nhz, dhz, dticks, est, lo_hz, hi_hz, tq;
    logic signed [63:0] diff, dt;
    logic [127:0] quot;
    logic far;
    int s, i;
    w.action = ACT_IGNORE; w.step_value = '0; w.slew_offset = '0; w.slew_span = '0;
    w.hz_update = 0;
    diff = '0;
    if (!p) begin
      if (period_secs > 900) next_wait = 900;
    end else if (srv[63] || !have_first) begin
      have_first = 1;
    end else begin
      if (loc[63]) begin
        mag = srv - loc;
        far = mag > LIMIT_NS;
        if (!far) diff = $signed(mag);
      end else begin
        diff = $signed(srv) - $signed(loc);
        far = diff > $signed(LIMIT_NS) || diff < -$signed(LIMIT_NS);
      end
      if (far) begin
        period_secs = 60;
        w.action = ACT_STEP;
        w.step_value = srv;
      end else begin
        ad = diff < 0 ? 64'(-diff) : 64'(diff);
        s = period_secs;
        err_avg = (err_avg >> 1) + (ad >> 1);
        if (ad < (acc_reg >> 1)) s = (s + 60 > 65535) ? 65535 : s + 60;
        else if (ad > acc_reg) s = s >> 1;
        else s = (s > 60) ? s - 60 : 0;
        if (s < 60) s = 60;
        period_secs = s; next_wait = s;
        w.action = ACT_SLEW;
        w.slew_offset = diff[34:0];
        w.slew_span = 18'(4 * s);
      end
      while (ring_fill >= 2 && $signed(srv) - $signed(ring_time[ring_slot(1)]) >= $signed(ONE_DAY)) begin
        ring_head = ring_slot(1);
        ring_fill--;
      end
      if (ring_fill > 0) begin
        per = err_avg << 24;
        i = 0;
        ohz = freq_hz; nhz = freq_hz;
        while (i + 1 < ring_fill && srv - ring_time[ring_slot(i)] >= per
               && srv - ring_time[ring_slot(i + 1)] >= per) i++;
        dt = $signed(srv) - $signed(ring_time[ring_slot(i)]);
        dticks = tck - ring_ticks[ring_slot(i)];
        if (dt > 0 && dticks != 0 && !dticks[63]) begin
          lo_hz = nom_reg - (nom_reg >> 2);
          hi_hz = nom_reg + (nom_reg >> 2);
          quot = (128'(dticks) * 128'(BILLION)) / 128'(dt);
          est = (quot[127:64] != 0) ? '1 : quot[63:0];
          if (est >= lo_hz && est <= hi_hz) begin
            if (per > 64'(dt)) est = (64'd12 * ohz + 64'd4 * est) / 64'd16;
            nhz = est;
            w.hz_update = 1;
          end
        end
        dhz = nhz >= ohz ? nhz - ohz : ohz - nhz;
        if (dhz != 0 && dhz * 64'(next_wait) >= tacc_reg) begin
          tq = tacc_reg / dhz;
          if (tq < 60) tq = 60;
          next_wait = 32'(tq);
        end
        freq_hz = nhz;
      end
      if (ring_fill >= DEPTH) begin
        ring_time[ring_head] = srv; ring_ticks[ring_head] = tck;
        ring_head = ring_slot(1);
      end else begin
        ring_time[ring_slot(ring_fill)] = srv; ring_ticks[ring_slot(ring_fill)] = tck;
        ring_fill++;
      end
    end
    w.new_hz = freq_hz;
    w.sleep_secs = next_wait[15:0];
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic send_word(input logic p, input logic [63:0] srv, input logic [63:0] loc,
                           input logic [63:0] tck);
    loop_word_t w;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_bus.valid <= 1'b1;
    in_bus.sample_present <= p;
    in_bus.server_time <= srv;
    in_bus.local_time <= loc;
    in_bus.tick_count <= tck;
    do @(posedge clk); while (!in_bus.ready);
    predict_loop(p, srv, loc, tck, w);
    pending_words.push_back(w);
    next_gap = pick_gap();
    if (next_gap > 0) in_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    if (next_gap == 0) in_bus.valid <= 1'b0;
    next_gap = 1;
    while (pending_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ACCURACY: begin
        acc_reg = val & ((64'd1 << 30) - 1);
        if (!have_first) err_avg = acc_reg >> 1;
      end
      REG_NOMINAL: nom_reg = val & ((64'd1 << 40) - 1);
      REG_START: begin
        start_reg = val & ((64'd1 << 40) - 1);
        if (!have_first) freq_hz = start_reg;
      end
      default: tacc_reg = val & ((64'd1 << 40) - 1);
    endcase
    next_gap = 1;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // one well-formed sample following the generated time line
  task automatic stream_sample();
    logic [63:0] secs, rate, off;
    int r;
    r = $urandom_range(0, 99);
    secs = (r < 5) ? 64'd90000 + $urandom_range(0, 9000) : 64'($urandom_range(1, 4000));
    rate = nom_reg + 64'($signed($urandom_range(0, 4000)) - 2000) * (nom_reg / 100000);
    if (r >= 95) begin
      gen_server = gen_server - secs * BILLION;
      gen_ticks = gen_ticks - 64'($urandom_range(0, 1000));
    end else begin
      gen_server = gen_server + secs * BILLION + $urandom_range(0, 999999);
      gen_ticks = gen_ticks + secs * rate;
    end
    r = $urandom_range(0, 99);
    if (r < 60) off = 64'($signed($urandom_range(0, 4 * 1000000)) - 2000000);
    else if (r < 70) off = 0;
    else if (r < 80) off = (acc_reg << 1) * ($urandom_range(0, 1) ? 64'd1 : -64'd1);
    else if (r < 88) off = $urandom_range(0, 1) ? LIMIT_NS : -LIMIT_NS;
    else off = ($urandom_range(0, 1) ? 64'd1 : -64'd1) * (LIMIT_NS + $urandom_range(1, 1 << 30));
    send_word(1'b1, gen_server & 64'h7fff_ffff_ffff_ffff, gen_server - off, gen_ticks);
  endtask

  task automatic noise_sample();
    logic [63:0] jitter;
    jitter = rand64();
    case ($urandom_range(0, 3))
      0: send_word(1'b0, rand64(), rand64(), rand64());
      1: send_word(1'b1, rand64() | 64'h8000_0000_0000_0000, rand64(), rand64());
      2: send_word(1'b1, rand64() >> 1, rand64(), rand64());
      default: send_word(1'b1, gen_server, gen_server + {23'd0, jitter[40:0]}, rand64());
    endcase
  endtask

  task automatic test_first_sample();
    write_reg(REG_ACCURACY, 64'hff_c000_1000);
    write_reg(REG_START, 64'd99990000);
    send_word(1'b0, '0, '0, '0);
    send_word(1'b1, 64'h8000_0000_0000_0000, '1, '1);
    send_word(1'b1, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, '0);
    drain();
    write_reg(REG_START, 64'd12345);
    write_reg(REG_ACCURACY, 64'd1000000);
  endtask

  task automatic test_offsets();
    gen_server = 64'd1000000000000; gen_ticks = 64'd5000;
    send_word(1'b1, gen_server, gen_server, gen_ticks);
    send_word(1'b1, gen_server + 60 * BILLION, gen_server + 60 * BILLION, gen_ticks + 64'd6000000000);
    send_word(1'b1, gen_server + 120 * BILLION, gen_server + 120 * BILLION - LIMIT_NS,
              gen_ticks + 64'd12000000000);
    send_word(1'b1, gen_server + 180 * BILLION, gen_server + 180 * BILLION + LIMIT_NS + 1,
              gen_ticks + 64'd18000000000);
    send_word(1'b1, gen_server + 240 * BILLION, gen_server + 240 * BILLION - LIMIT_NS - 1,
              gen_ticks + 64'd24000000000);
    send_word(1'b1, 64'd5, 64'h8000_0000_0000_0000, '0);
    send_word(1'b1, 64'd5, -64'd3, gen_ticks);
    send_word(1'b1, gen_server + 300 * BILLION, gen_server + 300 * BILLION + 64'd1,
              gen_ticks - 64'd1);
    send_word(1'b1, gen_server + 300 * BILLION + 1, gen_server + 300 * BILLION,
              64'h4000_0000_0000_0000);
    send_word(1'b1, gen_server + 360 * BILLION, gen_server + 360 * BILLION, '1);
    send_word(1'b1, gen_server + 420 * BILLION, gen_server + 420 * BILLION, gen_ticks + 64'd42000000000);
    send_word(1'b0, '1, '1, '1);
    drain();
    gen_server = gen_server + 420 * BILLION;
    gen_ticks = gen_ticks + 64'd42000000000;
  endtask

  task automatic test_frequency_tracking();
    repeat (12) stream_sample();
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_ACCURACY, 64'd2);
    write_reg(REG_NOMINAL, 64'd1);
    write_reg(REG_TICK_ACC, 64'd0);
    repeat (6) stream_sample();
    drain();
    write_reg(REG_ACCURACY, 64'd1000000000);
    write_reg(REG_NOMINAL, 64'hff_ffff_ffff);
    write_reg(REG_TICK_ACC, 64'hff_ffff_ffff);
    write_reg(REG_START, 64'hff_ffff_ffff);
    repeat (6) stream_sample();
    drain();
  endtask

  task automatic test_random_traffic();
    int k;
    write_reg(REG_ACCURACY, 64'd1000000);
    write_reg(REG_NOMINAL, 64'd100000000);
    write_reg(REG_TICK_ACC, 64'd100000);
    for (k = 0; k < 100; k++) begin
      quiet = (k >= 30 && k < 45);
      if ($urandom_range(0, 99) < 82) stream_sample();
      else noise_sample();
      if (k == 50) begin
        if (next_gap == 0) in_bus.valid <= 1'b0;
        next_gap = 1;
        while (pending_words.size() > 0) @(posedge clk);
      end
      if (k == 70) begin
        drain();
        write_reg(REG_ACCURACY, 64'($urandom_range(2, 5000000)));
        write_reg(REG_NOMINAL, 64'd100000000 + $urandom_range(0, 1000000));
        write_reg(REG_TICK_ACC, 64'($urandom_range(0, 10000000)));
      end
    end
    quiet = 0;
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 99) < 60) begin
      out_bus.ready <= 1'b1;
    end else begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
      out_bus.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    loop_word_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        e = pending_words.pop_front();
        words_checked++;
        if (e.action == ACT_STEP) steps_seen++;
        if (e.action == ACT_SLEW) slews_seen++;
        if (e.hz_update) hz_seen++;
        if (out_bus.action !== e.action || out_bus.step_value !== e.step_value
            || out_bus.slew_offset !== e.slew_offset || out_bus.slew_span !== e.slew_span
            || out_bus.hz_update !== e.hz_update || out_bus.new_hz !== e.new_hz
            || out_bus.sleep_secs !== e.sleep_secs) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch word %0d exp act=%0d step=%0h slew=%0h span=%0d upd=%0b hz=%0d wait=%0d",
                     words_checked, e.action, e.step_value, e.slew_offset, e.slew_span,
                     e.hz_update, e.new_hz, e.sleep_secs);
            $display("                 got act=%0d step=%0h slew=%0h span=%0d upd=%0b hz=%0d wait=%0d",
                     out_bus.action, out_bus.step_value, out_bus.slew_offset, out_bus.slew_span,
                     out_bus.hz_update, out_bus.new_hz, out_bus.sleep_secs);
          end
        end
      end
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.sample_present = 1'b0;
    in_bus.server_time = '0;
    in_bus.local_time = '0;
    in_bus.tick_count = '0;
    out_bus.ready = 1'b0;
    loop_reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample();
    test_offsets();
    test_frequency_tracking();
    test_config_extremes();
    test_random_traffic();
    repeat (200) @(posedge clk);
    $display("checked %0d result words: %0d steps, %0d slews, %0d frequency updates",
             words_checked, steps_seen, slews_seen, hz_seen);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, pending_words.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
